// File: hdl/ptc_pkg.sv
// ptc_pkg: shared types and codes for the paper tape channel controller
// used by ptc_step, ptc_state and paper_tape_channel_controller; no dependencies
package ptc_pkg;

  // request kinds carried in the input tuser
  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_TEST_IO = 3'd1,
    KIND_TEST_DV = 3'd2,
    KIND_HALT    = 3'd3,
    KIND_ACK     = 3'd4,
    KIND_TICK    = 3'd5
  } kind_t;

  // transfer thread state, one-hot
  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_INIT  = 6'b000010,
    MODE_WRITE = 6'b000100,
    MODE_READ  = 6'b001000,
    MODE_READI = 6'b010000,
    MODE_END   = 6'b100000
  } mode_t;

  // channel action codes
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_FETCH   = 3'd1;
  localparam logic [2:0] ACT_XFER    = 3'd2;
  localparam logic [2:0] ACT_CHEND   = 3'd3;
  localparam logic [2:0] ACT_UNUSUAL = 3'd4;

  // channel fault flags
  localparam logic [1:0] FLT_NONE   = 2'd0;
  localparam logic [1:0] FLT_LENGTH = 2'd1;
  localparam logic [1:0] FLT_DATA   = 2'd2;

  // stop codes
  localparam logic [2:0] STOP_OK      = 3'd0;
  localparam logic [2:0] STOP_UNATT   = 3'd1;
  localparam logic [2:0] STOP_IOERR   = 3'd2;
  localparam logic [2:0] STOP_CHERR   = 3'd3;
  localparam logic [2:0] STOP_ILLEGAL = 3'd4;

  // command bytes
  localparam logic [7:0] CMD_WRITE    = 8'h01;
  localparam logic [7:0] CMD_READ     = 8'h02;
  localparam logic [7:0] CMD_READI    = 8'h82;
  localparam logic [7:0] CMD_MOD_MASK = 8'h7F;

  // configuration register indexes
  localparam logic [1:0] CFG_READER_ATT  = 2'd0;
  localparam logic [1:0] CFG_PUNCH_ATT   = 2'd1;
  localparam logic [1:0] CFG_READER_STOP = 2'd2;
  localparam logic [1:0] CFG_PUNCH_STOP  = 2'd3;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic       punch_fault;
    logic       tape_fault;
    logic       tape_end;
    logic [7:0] tape_byte;
    logic       chan_chain;
    logic       chan_count_zero;
    logic       chan_error;
    logic [7:0] chan_byte;
    logic [7:0] chan_command;
  } payload_t;

  typedef struct packed {
    logic [2:0] kind;
    payload_t   pl;
  } item_t;

  typedef struct packed {
    logic [2:0] stop_code;
    logic       clear_interrupt;
    logic [1:0] chan_fault_flag;
    logic [2:0] chan_action;
    logic [7:0] punch_data;
    logic       punch_valid;
    logic [7:0] mem_write_byte;
    logic       mem_write_valid;
    logic       punch_manual;
    logic       reader_manual;
    logic       status_ready;
    logic       status_busy;
  } result_t;

  typedef struct packed {
    logic reader_attached;
    logic punch_attached;
    logic reader_stop_unattached;
    logic punch_stop_unattached;
  } cfg_t;

  // next thread state handed from the step logic to the state registers
  typedef struct packed {
    mode_t mode;
    logic  leader_seen;
  } thread_t;

endpackage

// File: hdl/ptc_state.sv
// ptc_state: thread state and configuration registers
// depends on ptc_pkg
module ptc_state (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  ptc_pkg::thread_t thr_nxt,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic             cfg_wdata,
  output ptc_pkg::thread_t thr_r,
  output ptc_pkg::cfg_t    cfg_r
);

  ptc_pkg::thread_t state_nxt;

  // thread state follows each request leaving the input stage
  // any write to the reader attach register forgets the leader
  always_comb begin
    state_nxt = advance ? thr_nxt : thr_r;
    if (cfg_we && cfg_index == ptc_pkg::CFG_READER_ATT) begin
      state_nxt.leader_seen = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.mode        <= ptc_pkg::MODE_IDLE;
      thr_r.leader_seen <= 1'b0;
    end else begin
      thr_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reader_attached        <= 1'b0;
      cfg_r.punch_attached         <= 1'b0;
      cfg_r.reader_stop_unattached <= 1'b1;
      cfg_r.punch_stop_unattached  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ptc_pkg::CFG_READER_ATT:  cfg_r.reader_attached        <= cfg_wdata;
        ptc_pkg::CFG_PUNCH_ATT:   cfg_r.punch_attached         <= cfg_wdata;
        ptc_pkg::CFG_READER_STOP: cfg_r.reader_stop_unattached <= cfg_wdata;
        ptc_pkg::CFG_PUNCH_STOP:  cfg_r.punch_stop_unattached  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/ptc_step.sv
// ptc_step: combinational result and next state for one request
// depends on ptc_pkg
module ptc_step (
  input  ptc_pkg::item_t   item,
  input  ptc_pkg::thread_t thr,
  input  ptc_pkg::cfg_t    cfg,
  output ptc_pkg::result_t res,
  output ptc_pkg::thread_t thr_nxt
);

  logic       busy;
  logic       ready;
  logic       leader_set;
  logic [7:0] cmd;

  assign busy       = (thr.mode != ptc_pkg::MODE_IDLE);
  assign ready      = cfg.reader_attached & cfg.punch_attached;
  assign cmd        = item.pl.chan_command;
  assign leader_set = thr.leader_seen | (item.pl.tape_byte != 8'd0);

  always_comb begin
    res     = '0;
    thr_nxt = thr;
    case (item.kind)
      ptc_pkg::KIND_START: begin
        res.status_busy  = busy;
        res.status_ready = ready;
        if (!busy) begin
          thr_nxt.mode = ptc_pkg::MODE_INIT;
        end
      end
      ptc_pkg::KIND_TEST_IO: begin
        res.status_busy  = busy;
        res.status_ready = ready;
      end
      ptc_pkg::KIND_TEST_DV: begin
        res.reader_manual = ~cfg.reader_attached;
        res.punch_manual  = ~cfg.punch_attached;
      end
      ptc_pkg::KIND_HALT: begin
        res.clear_interrupt = 1'b1;
        res.status_busy     = busy;
        res.status_ready    = ready;
        if (busy) begin
          thr_nxt.mode    = ptc_pkg::MODE_IDLE;
          res.chan_action = ptc_pkg::ACT_UNUSUAL;
        end
      end
      ptc_pkg::KIND_ACK: begin
        res.clear_interrupt = 1'b1;
      end
      ptc_pkg::KIND_TICK: begin
        case (thr.mode)
          // command fetch
          ptc_pkg::MODE_INIT: begin
            res.chan_action = ptc_pkg::ACT_FETCH;
            if (item.pl.chan_error) begin
              thr_nxt.mode    = ptc_pkg::MODE_IDLE;
              res.chan_action = ptc_pkg::ACT_UNUSUAL;
              res.stop_code   = ptc_pkg::STOP_CHERR;
            end else if (cmd == ptc_pkg::CMD_WRITE) begin
              thr_nxt.mode = ptc_pkg::MODE_WRITE;
            end else if ((cmd & ptc_pkg::CMD_MOD_MASK) == ptc_pkg::CMD_READ) begin
              thr_nxt.mode = (cmd == ptc_pkg::CMD_READI) ? ptc_pkg::MODE_READI
                                                         : ptc_pkg::MODE_READ;
            end else begin
              thr_nxt.mode = ptc_pkg::MODE_END;
            end
          end
          // reader to memory
          ptc_pkg::MODE_READ, ptc_pkg::MODE_READI: begin
            if (!cfg.reader_attached) begin
              res.stop_code = cfg.reader_stop_unattached ? ptc_pkg::STOP_UNATT
                                                         : ptc_pkg::STOP_OK;
            end else if (item.pl.tape_end) begin
              res.chan_fault_flag = ptc_pkg::FLT_LENGTH;
              thr_nxt.mode        = ptc_pkg::MODE_END;
            end else if (item.pl.tape_fault) begin
              thr_nxt.mode        = ptc_pkg::MODE_IDLE;
              res.chan_fault_flag = ptc_pkg::FLT_DATA;
              res.chan_action     = ptc_pkg::ACT_UNUSUAL;
              res.stop_code       = ptc_pkg::STOP_IOERR;
            end else begin
              thr_nxt.leader_seen = leader_set;
              if (thr.mode == ptc_pkg::MODE_READI || leader_set) begin
                res.chan_action = ptc_pkg::ACT_XFER;
                if (item.pl.chan_error) begin
                  thr_nxt.mode    = ptc_pkg::MODE_IDLE;
                  res.chan_action = ptc_pkg::ACT_UNUSUAL;
                  res.stop_code   = ptc_pkg::STOP_CHERR;
                end else begin
                  res.mem_write_valid = 1'b1;
                  res.mem_write_byte  = item.pl.tape_byte;
                  if (item.pl.chan_count_zero) begin
                    thr_nxt.mode = ptc_pkg::MODE_END;
                  end
                end
              end
            end
          end
          // memory to punch
          ptc_pkg::MODE_WRITE: begin
            if (!cfg.punch_attached) begin
              res.stop_code = cfg.punch_stop_unattached ? ptc_pkg::STOP_UNATT
                                                        : ptc_pkg::STOP_OK;
            end else begin
              res.chan_action = ptc_pkg::ACT_XFER;
              if (item.pl.chan_error) begin
                thr_nxt.mode    = ptc_pkg::MODE_IDLE;
                res.chan_action = ptc_pkg::ACT_UNUSUAL;
                res.stop_code   = ptc_pkg::STOP_CHERR;
              end else if (item.pl.punch_fault) begin
                thr_nxt.mode        = ptc_pkg::MODE_IDLE;
                res.chan_fault_flag = ptc_pkg::FLT_DATA;
                res.chan_action     = ptc_pkg::ACT_UNUSUAL;
                res.stop_code       = ptc_pkg::STOP_IOERR;
              end else begin
                res.punch_valid = 1'b1;
                res.punch_data  = item.pl.chan_byte;
                if (item.pl.chan_count_zero) begin
                  thr_nxt.mode = ptc_pkg::MODE_END;
                end
              end
            end
          end
          // channel end, optional chaining
          ptc_pkg::MODE_END: begin
            res.chan_action = ptc_pkg::ACT_CHEND;
            if (item.pl.chan_error) begin
              thr_nxt.mode    = ptc_pkg::MODE_IDLE;
              res.chan_action = ptc_pkg::ACT_UNUSUAL;
              res.stop_code   = ptc_pkg::STOP_CHERR;
            end else begin
              thr_nxt.mode = item.pl.chan_chain ? ptc_pkg::MODE_INIT
                                                : ptc_pkg::MODE_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: begin
        res.stop_code = ptc_pkg::STOP_ILLEGAL;
      end
    endcase
  end

endmodule

// File: hdl/paper_tape_channel_controller.sv
// paper_tape_channel_controller: top level, input and result registers around the step logic
// depends on ptc_pkg, ptc_step, ptc_state
// path: an accepted request waits in the input register, its result in the result register
// throughput: one request per cycle while out_tready is high; input refills as output drains
// the only loop is the thread state register, updated as each request advances
// reset: synchronous active-low rst_n empties both registers, sets the thread idle and
//   the configuration to its defaults (no units attached, stop when unattached)
module paper_tape_channel_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] chan_command, [15:8] chan_byte, [16] chan_error, [17] chan_count_zero,
  // [18] chan_chain, [26:19] tape_byte, [27] tape_end, [28] tape_fault, [29] punch_fault
  input  logic [ptc_pkg::IN_DATA_W-1:0] in_tdata,
  // [2:0] kind
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] status_busy, [1] status_ready, [2] reader_manual, [3] punch_manual,
  // [4] mem_write_valid, [12:5] mem_write_byte, [13] punch_valid, [21:14] punch_data,
  // [24:22] chan_action, [26:25] chan_fault_flag, [27] clear_interrupt, [30:28] stop_code
  output logic [ptc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_wdata
);

  ptc_pkg::item_t   item_r;
  logic             item_v_r;
  ptc_pkg::result_t res_r;
  logic             res_v_r;
  ptc_pkg::result_t res_nxt;
  ptc_pkg::thread_t thr_r;
  ptc_pkg::thread_t thr_nxt;
  ptc_pkg::cfg_t    cfg_r;
  logic             advance;

  // a request moves on when the result register is free or being drained
  assign advance   = item_v_r & (~res_v_r | out_tready);
  assign in_tready = ~item_v_r | advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind <= in_tuser;
      item_r.pl   <= in_tdata[$bits(ptc_pkg::payload_t)-1:0];
    end
  end

  ptc_step u_step (
    .item    (item_r),
    .thr     (thr_r),
    .cfg     (cfg_r),
    .res     (res_nxt),
    .thr_nxt (thr_nxt)
  );

  ptc_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .thr_nxt   (thr_nxt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr_r     (thr_r),
    .cfg_r     (cfg_r)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (advance) begin
      res_v_r <= 1'b1;
    end else if (out_tready) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = {{(ptc_pkg::OUT_DATA_W - $bits(ptc_pkg::result_t)){1'b0}}, res_r};

endmodule
